### src/sabs_pkg.sv
package sabs_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int BND_W       = CNT_W + 1;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_SEARCH = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_SEARCH,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } cmd_t;

endpackage

### src/sabs_front.sv
module sabs_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [1:0]                func,
  input  logic signed [31:0]        value,
  output logic                      full,
  output logic                      cmd_valid,
  output sabs_pkg::cmd_t            cmd,
  input  logic                      cmd_take
);
  import sabs_pkg::*;

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_take;
  cmd_t              incoming;

  function automatic op_t classify(input logic [1:0] f);
    op_t o;
    unique case (f)
      FUNC_APPEND: o = OP_APPEND;
      FUNC_SEARCH: o = OP_SEARCH;
      FUNC_CLEAR:  o = OP_CLEAR;
      default:     o = OP_NONE;
    endcase
    return o;
  endfunction

  assign full      = (fill == QCNT_W'(QDEPTH));
  assign cmd_valid = (fill != '0);
  assign do_push   = push && !full;
  assign do_take   = cmd_take && cmd_valid;
  assign cmd       = slots[rd_ptr];

  always_comb begin
    incoming.op    = classify(func);
    incoming.value = value;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_take) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_take})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### src/sabs_back.sv
module sabs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  sabs_pkg::cmd_t cmd,
  output logic           cmd_take,
  input  logic           pop,
  output logic           res_valid,
  output logic           res_found,
  output logic           res_overflow
);
  import sabs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_PROBE = 3'b010,
    S_CMP   = 3'b100
  } state_t;

  state_t                   state;
  logic [31:0]              mem [MAX_ENTRIES];
  logic signed [31:0]       rd_data;
  logic [CNT_W-1:0]         count;
  logic signed [31:0]       key;
  logic signed [BND_W-1:0]  lo;
  logic signed [BND_W-1:0]  hi;
  logic [IDX_W-1:0]         mid;
  logic signed [BND_W-1:0]  mid_calc;
  logic signed [BND_W-1:0]  mid_ext;
  logic signed [BND_W-1:0]  lo_next;
  logic signed [BND_W-1:0]  hi_next;
  logic                     is_full;
  logic                     pop_ok;
  logic                     res_done;

  assign is_full  = (count == CNT_W'(MAX_ENTRIES));
  assign pop_ok   = pop && res_valid;
  assign cmd_take = (state == S_IDLE) && cmd_valid && (!res_valid || pop);
  assign mid_calc = lo + ((hi - lo) >>> 1);
  assign mid_ext  = $signed(BND_W'(mid));

  // a result is ready: any non-search command, a search of an empty array,
  // or a probe that matched or crossed the bounds
  assign res_done = (cmd_take && ((cmd.op != OP_SEARCH) || (count == '0)))
                    || ((state == S_CMP) && ((rd_data == key) || (lo_next > hi_next)));

  // narrow the bounds around the probed entry
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (rd_data > key) begin
      hi_next = mid_ext - BND_W'(1);
    end else begin
      lo_next = mid_ext + BND_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && (cmd.op == OP_APPEND) && !is_full) begin
      mem[count[IDX_W-1:0]] <= cmd.value;
    end
    if (state == S_PROBE) begin
      rd_data <= $signed(mem[mid_calc[IDX_W-1:0]]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_done) begin
        res_valid <= 1'b1;
      end else if (pop_ok) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            res_found    <= 1'b0;
            res_overflow <= 1'b0;
            case (cmd.op)
              OP_APPEND: begin
                if (is_full) begin
                  res_overflow <= 1'b1;
                end else begin
                  count <= count + 1'b1;
                end
              end
              OP_SEARCH: begin
                key <= cmd.value;
                lo  <= '0;
                hi  <= $signed(BND_W'(count)) - BND_W'(1);
                if (count != '0) begin
                  state <= S_PROBE;
                end
              end
              OP_CLEAR: begin
                count <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_PROBE: begin
          mid   <= mid_calc[IDX_W-1:0];
          state <= S_CMP;
        end
        S_CMP: begin
          if (rd_data == key) begin
            res_found <= 1'b1;
            state     <= S_IDLE;
          end else if (lo_next > hi_next) begin
            state     <= S_IDLE;
          end else begin
            lo    <= lo_next;
            hi    <= hi_next;
            state <= S_PROBE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/sorted_array_binary_search_top.sv
// Sorted-array membership block with binary search.
// Input channel: push/full, payload func and value. A transaction completes on a
// rising edge with push high and full low. func 0 appends value to the array,
// 1 searches for value, 2 clears the array; code 3 does nothing.
// Result channel: empty/pop, payload found and overflow. The oldest result sits on
// the ports while empty is low; a transaction completes on an edge with pop high.
// Every input transaction gives exactly one result, in order.
// A two-entry command queue takes input transactions while the search engine works
// and while a finished result waits, so the sender stalls only once it fills.
// Append, clear and the unused code go into a queue slot; the engine takes them from
// there and registers the result. A search repeats a probe, PROBE (address and
// registered memory read) then CMP (compare), at most log2(entries)+1 times.
// The entry memory allows one read per cycle; each probe reads it once.
// Reset empties the queue and the result register and sets the entry count to zero;
// no clearing pass runs, since only entries below the count are ever read.
// When the receiver does not pop, the engine holds its result and stops taking
// commands; the queue then fills and full rises.
module sorted_array_binary_search_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         func,
  input  logic signed [31:0] value,
  output logic               empty,
  input  logic               pop,
  output logic               found,
  output logic               overflow
);
  import sabs_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_take;
  logic res_valid;

  // front: accept and classify, buffer commands
  sabs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .func      (func),
    .value     (value),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  // back: hold the entries, run appends, clears and searches
  sabs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .pop          (pop),
    .res_valid    (res_valid),
    .res_found    (found),
    .res_overflow (overflow)
  );

  assign empty = !res_valid;

`ifndef SYNTHESIS
  // never take a command while an unread result still occupies the output slot
  a_take_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> (empty || pop))
    else $error("command taken while result slot busy");

  // a command is only taken from a non-empty queue
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");

  // a result never reports both found and overflow
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !(found && overflow))
    else $error("found and overflow both set");

  // a pending result holds until popped
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(found) && $stable(overflow)))
    else $error("pending result changed before pop");
`endif

endmodule

### tb/tb_sorted_array_binary_search_top.sv
`timescale 1ns / 1ps

module tb_sorted_array_binary_search_top;
  import sabs_pkg::*;

  // func code 3 has no constant in the package; the block ignores it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CALM_ITEMS   = 150;

  // Scoreboard: keeps its own copy of the sorted array, predicts the flags
  // of every accepted transaction and checks each popped result in order.
  class membership_board;
    logic signed [31:0] stored [0:MAX_ENTRIES-1];
    int                 stored_count;
    logic [1:0]         expected_flags [$];   // {found, overflow}
    int                 errors;
    int                 searches;
    int                 hits;
    int                 overflows;
    int                 unused_codes;
    int                 results_seen;

    function new();
      stored_count = 0;
      errors       = 0;
      searches     = 0;
      hits         = 0;
      overflows    = 0;
      unused_codes = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return expected_flags.size();
    endfunction

    // Predict the flags of one accepted input transaction.
    function void note_transaction(logic [1:0] f, logic signed [31:0] v);
      logic hit;
      logic ovf;
      int   lo;
      int   hi;
      int   mid;
      hit = 1'b0;
      ovf = 1'b0;
      case (f)
        FUNC_APPEND: begin
          if (stored_count < MAX_ENTRIES) begin
            stored[stored_count] = v;
            stored_count++;
          end else begin
            ovf = 1'b1;
            overflows++;
          end
        end
        FUNC_SEARCH: begin
          searches++;
          lo = 0;
          hi = stored_count - 1;
          while (lo <= hi && !hit) begin
            mid = lo + (hi - lo) / 2;
            if (stored[mid] == v) hit = 1'b1;
            else if (stored[mid] > v) hi = mid - 1;
            else lo = mid + 1;
          end
          if (hit) hits++;
        end
        FUNC_CLEAR: stored_count = 0;
        default: unused_codes++;
      endcase
      expected_flags.push_back({hit, ovf});
    endfunction

    task report_mismatch(string what, logic got, logic want);
      $display("%0t ns: mismatch on %s: got %0b, expected %0b", $time, what, got, want);
      errors++;
    endtask

    task check_transaction(logic got_found, logic got_overflow);
      logic [1:0] want;
      results_seen++;
      if (expected_flags.size() == 0) begin
        $display("%0t ns: result popped with nothing expected", $time);
        errors++;
      end else begin
        want = expected_flags.pop_front();
        if (got_found !== want[1]) report_mismatch("found", got_found, want[1]);
        if (got_overflow !== want[0]) report_mismatch("overflow", got_overflow, want[0]);
      end
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               push;
  logic               full;
  logic [1:0]         func;
  logic signed [31:0] value;
  logic               empty;
  logic               pop;
  logic               found;
  logic               overflow;

  membership_board board;
  int  items_sent;
  bit  calm;        // no idling on either side near the end of the run
  bit  send_bursty; // sender idles in bursts during the current sequence

  sorted_array_binary_search_top uut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .func     (func),
    .value    (value),
    .empty    (empty),
    .pop      (pop),
    .found    (found),
    .overflow (overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Drive one input transaction and hold it until the block takes it.
  task send_item(logic [1:0] f, logic signed [31:0] v);
    int gap;
    bit taken;
    if (!calm && send_bursty && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
    end
    @(negedge clk);
    push  <= 1'b1;
    func  <= f;
    value <= v;
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      if (!full) taken = 1;
    end
    board.note_transaction(f, v);
    items_sent++;
  endtask

  // Drop push and hold off until every expected result has been popped.
  task drain_results();
    @(negedge clk);
    push <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Clear, then load n ascending values (sometimes repeated) and remember them.
  task load_ascending(int n, inout int keys [$]);
    longint cur;
    longint span;
    longint step_cap;
    keys.delete();
    send_item(FUNC_CLEAR, $urandom);
    span = 64'h1_0000_0000 / (n + 1);
    step_cap = (2 * span > 64'hffff_ffff) ? 64'hffff_ffff : 2 * span;
    cur = -64'sd2147483648 + longint'($urandom_range(0, 32'(span)));
    for (int i = 0; i < n; i++) begin
      if (cur > 64'sd2147483647) cur = 64'sd2147483647;
      send_item(FUNC_APPEND, 32'(cur));
      keys.push_back(int'(32'(cur)));
      if ($urandom_range(0, 7) != 0) cur += longint'($urandom_range(0, 32'(step_cap)));
    end
  endtask

  // Searches that hit stored keys, their neighbors, the extremes, or random keys.
  task automatic search_burst(int k, ref int keys [$]);
    int key;
    int pick;
    for (int i = 0; i < k; i++) begin
      pick = $urandom_range(0, 9);
      if (keys.size() == 0 || pick >= 8) key = $urandom;
      else if (pick == 7) key = ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX;
      else begin
        key = keys[$urandom_range(0, keys.size() - 1)];
        if (pick == 5) key = key + 1;
        if (pick == 6) key = key - 1;
      end
      send_item(FUNC_SEARCH, key);
    end
  endtask

  // Receiver: pop, with random stall bursts while the run is not calm.
  initial begin
    int stall_left;
    stall_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 9);
      end
    end
  end

  // Sample the result channel at the rising edge.
  always @(posedge clk) begin
    if (!rst && pop && !empty) board.check_transaction(found, overflow);
  end

  // Main stimulus.
  initial begin
    int keys [$];
    int n;
    int kind;
    int seq_idx;
    board = new();
    clk   = 1'b0;
    rst   = 1'b1;
    push  = 1'b0;
    func  = FUNC_APPEND;
    value = '0;
    pop   = 1'b0;
    items_sent  = 0;
    calm        = 0;
    send_bursty = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty search, extremes, absent keys, unused code, clear,
    // and an out-of-order array.
    send_item(FUNC_SEARCH, 32'sd0);
    send_item(FUNC_UNUSED, VAL_MAX);
    send_item(FUNC_APPEND, VAL_MIN);
    send_item(FUNC_APPEND, -32'sd1);
    send_item(FUNC_APPEND, 32'sd0);
    send_item(FUNC_APPEND, 32'sd1);
    send_item(FUNC_APPEND, VAL_MAX);
    send_item(FUNC_SEARCH, VAL_MIN);
    send_item(FUNC_SEARCH, VAL_MAX);
    send_item(FUNC_SEARCH, 32'sd0);
    send_item(FUNC_SEARCH, 32'sd2);
    send_item(FUNC_SEARCH, -32'sd2);
    send_item(FUNC_UNUSED, VAL_MIN);
    send_item(FUNC_SEARCH, 32'sd1);
    send_item(FUNC_CLEAR, -32'sd1);
    send_item(FUNC_SEARCH, 32'sd0);
    send_item(FUNC_APPEND, 32'sd5);
    send_item(FUNC_APPEND, 32'sd3);
    send_item(FUNC_SEARCH, 32'sd3);
    send_item(FUNC_SEARCH, 32'sd5);
    send_item(FUNC_CLEAR, 32'sd0);
    drain_results();

    // Random: mostly sorted loads followed by searches, plus full-array
    // overflow runs, unsorted loads and raw noise.
    seq_idx = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent > RANDOM_ITEMS - CALM_ITEMS) calm = 1;
      send_bursty = ($urandom_range(0, 2) != 0);
      kind = $urandom_range(0, 19);
      if (seq_idx == 2 || (kind == 0 && !calm)) begin
        // fill the whole array, then push past the end
        load_ascending(MAX_ENTRIES, keys);
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_item(FUNC_APPEND, $urandom);
        search_burst($urandom_range(6, 16), keys);
      end else if (kind <= 15) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom_range(1, 12);
        load_ascending(n, keys);
        search_burst($urandom_range(1, 12), keys);
      end else if (kind <= 17) begin
        // unsorted contents: the probe sequence still decides the answer
        send_item(FUNC_CLEAR, $urandom);
        keys.delete();
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          keys.push_back($urandom);
          send_item(FUNC_APPEND, keys[i]);
        end
        search_burst($urandom_range(1, 8), keys);
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_item(2'($urandom_range(0, 3)), $urandom);
      end
      if (!calm && $urandom_range(0, 5) == 0) drain_results();
      seq_idx++;
    end

    // Wind down: wait for every result, then allow for the longest search.
    drain_results();
    repeat (40) @(posedge clk);
    if (board.pending() != 0) begin
      $display("%0d expected results never arrived", board.pending());
      board.errors++;
    end
    $display("Covered %0d transactions: %0d searches (%0d hits), %0d dropped appends,",
             items_sent, board.searches, board.hits, board.overflows);
    $display("%0d unused-code items, %0d results checked, %0d errors",
             board.unused_codes, board.results_seen, board.errors);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin
    #1000000;
    $display("Timeout after %0d transactions", items_sent);
    $display("FAIL");
    $finish;
  end

endmodule
